[hdl/fp8r_pkg.sv]
// Package: shared types and constants of the E4M3 rounding and packing block.
`timescale 1ns / 1ps
package fp8r_pkg;

	// Rounding mode codes (codes 6 and 7 act as toward zero)
	localparam logic [2:0] RM_NEAR_EVEN = 3'd0;
	localparam logic [2:0] RM_TO_ZERO   = 3'd1;
	localparam logic [2:0] RM_DOWN      = 3'd2;
	localparam logic [2:0] RM_UP        = 3'd3;
	localparam logic [2:0] RM_NEAR_MAX  = 3'd4;
	localparam logic [2:0] RM_ODD       = 3'd5;

	// Configuration register indexes (byte address = 4 * index)
	localparam int          ADDR_W          = 5;
	localparam logic [2:0] REG_ROUND_MODE  = 3'd0;
	localparam logic [2:0] REG_TINY_BEFORE = 3'd1;
	localparam logic [2:0] REG_OFP8        = 3'd2;
	localparam logic [2:0] REG_SAT_EN      = 3'd3;
	localparam logic [2:0] REG_SAT_OPS     = 3'd4;
	localparam logic [2:0] REG_OVF_FLAG_EN = 3'd5;

	// Rounding increments added below the kept mantissa
	localparam logic [2:0] INC_HALF = 3'h4;
	localparam logic [2:0] INC_FULL = 3'h7;

	// Exponent limits and packed overflow codes (magnitude only)
	localparam logic [6:0] OFP8_MAX_EXP  = 7'h0E;
	localparam logic [6:0] IEEE_MAX_EXP  = 7'h0D;
	localparam logic [4:0] OFP8_MANT_LIM = 5'h0F;
	localparam logic [6:0] OFP8_NAN      = 7'h7F;
	localparam logic [6:0] OFP8_MAX_FIN  = 7'h7E;
	localparam logic [6:0] IEEE_INF      = 7'h78;
	localparam logic [6:0] IEEE_MAX_FIN  = 7'h77;

	// Configuration register set
	typedef struct packed {
		logic [2:0] rounding_mode;
		logic       tininess_before_rounding;
		logic       ofp8_format;
		logic       saturate_enable;
		logic       saturate_operations;
		logic       overflow_flag_enable;
	} fp8r_cfg_t;

	// One unpacked input item
	typedef struct packed {
		logic              sign_bit;
		logic signed [7:0] exponent;
		logic [6:0]        significand;
		logic              is_conversion;
	} fp8r_item_t;

	// One packed result item
	typedef struct packed {
		logic [7:0] packed_value;
		logic       flag_inexact;
		logic       flag_underflow;
		logic       flag_overflow;
	} fp8r_result_t;

endpackage

[hdl/fp8r_if.sv]
// Interfaces: valid/ready channels for input items and packed results.
`timescale 1ns / 1ps
interface fp8r_in_if;
	logic              valid;
	logic              ready;
	logic              sign_bit;
	logic signed [7:0] exponent;
	logic [6:0]        significand;
	logic              is_conversion;

	modport source (output valid, sign_bit, exponent, significand, is_conversion, input ready);
	modport sink   (input valid, sign_bit, exponent, significand, is_conversion, output ready);
endinterface

interface fp8r_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] packed_value;
	logic       flag_inexact;
	logic       flag_underflow;
	logic       flag_overflow;

	modport source (output valid, packed_value, flag_inexact, flag_underflow, flag_overflow,
		input ready);
	modport sink   (input valid, packed_value, flag_inexact, flag_underflow, flag_overflow,
		output ready);
endinterface

[hdl/fp8r_round.sv]
// Rounding datapath: denormal jamming, rounding, overflow handling and packing.
`timescale 1ns / 1ps
module fp8r_round (
	input  fp8r_pkg::fp8r_cfg_t    cfg,
	input  fp8r_pkg::fp8r_item_t   item,
	output fp8r_pkg::fp8r_result_t result
);

	logic [2:0] inc;
	logic       neg_exp;
	logic [7:0] shamt;
	logic [7:0] sum_pre;
	logic       tiny;
	logic [6:0] mask;
	logic       sticky;
	logic [6:0] jammed;
	logic [6:0] sig;
	logic [6:0] exp_eff;
	logic [2:0] rb;
	logic [7:0] rsum;
	logic [4:0] r;
	logic       ovf;
	logic [3:0] exp_field;
	logic [7:0] normal_val;
	logic [6:0] ovf_mag;
	logic       ovf_flag;

	// Increment chosen by mode and sign
	always_comb begin
		inc = 3'h0;
		if (cfg.rounding_mode == fp8r_pkg::RM_NEAR_EVEN ||
			cfg.rounding_mode == fp8r_pkg::RM_NEAR_MAX) begin
			inc = fp8r_pkg::INC_HALF;
		end else if ((item.sign_bit && cfg.rounding_mode == fp8r_pkg::RM_DOWN) ||
			(!item.sign_bit && cfg.rounding_mode == fp8r_pkg::RM_UP)) begin
			inc = fp8r_pkg::INC_FULL;
		end
	end

	// Tiny values: right shift by -exponent with sticky jam, exponent forced to 0
	assign neg_exp = item.exponent[7];
	assign shamt   = 8'(~item.exponent) + 8'd1;
	assign sum_pre = {1'b0, item.significand} + {5'b0, inc};
	assign tiny    = neg_exp && (cfg.tininess_before_rounding ||
		item.exponent != 8'shFF || !sum_pre[7]);
	assign mask    = (7'd1 << shamt[2:0]) - 7'd1;
	assign sticky  = |(item.significand & mask);

	always_comb begin
		if (|shamt[7:3]) begin
			jammed = {6'b0, |item.significand};
		end else begin
			jammed = (item.significand >> shamt[2:0]) | {6'b0, sticky};
		end
	end

	assign sig     = neg_exp ? jammed : item.significand;
	assign exp_eff = neg_exp ? 7'd0 : item.exponent[6:0];

	// Round the significand to three mantissa bits plus hidden bit
	assign rb   = sig[2:0];
	assign rsum = {1'b0, sig} + {5'b0, inc};

	always_comb begin
		r = rsum[7:3];
		if (rb != 3'b000 && cfg.rounding_mode == fp8r_pkg::RM_ODD) begin
			r = r | 5'd1;
		end else if (cfg.rounding_mode == fp8r_pkg::RM_NEAR_EVEN && rb == 3'b100) begin
			r = r & ~5'd1;
		end
	end

	// Overflow test on the rounded value
	always_comb begin
		if (cfg.ofp8_format) begin
			ovf = exp_eff > fp8r_pkg::OFP8_MAX_EXP ||
				(exp_eff == fp8r_pkg::OFP8_MAX_EXP && r >= fp8r_pkg::OFP8_MANT_LIM);
		end else begin
			ovf = exp_eff > fp8r_pkg::IEEE_MAX_EXP ||
				(exp_eff == fp8r_pkg::IEEE_MAX_EXP && r[4]);
		end
	end

	// Overflow magnitude and flag
	always_comb begin
		if (cfg.ofp8_format) begin
			if (cfg.saturate_enable && (cfg.saturate_operations || item.is_conversion)) begin
				ovf_mag = fp8r_pkg::OFP8_MAX_FIN;
			end else begin
				ovf_mag = (inc != 3'h0) ? fp8r_pkg::OFP8_NAN : fp8r_pkg::OFP8_MAX_FIN;
			end
			ovf_flag = cfg.saturate_enable ? cfg.overflow_flag_enable : 1'b1;
		end else begin
			ovf_mag  = (inc != 3'h0) ? fp8r_pkg::IEEE_INF : fp8r_pkg::IEEE_MAX_FIN;
			ovf_flag = 1'b1;
		end
	end

	// Normal packing: hidden bit carries into the exponent field
	assign exp_field  = (r == 5'd0) ? 4'd0 : exp_eff[3:0];
	assign normal_val = {item.sign_bit, 7'b0} + {1'b0, exp_field, 3'b000} + {3'b000, r};

	always_comb begin
		if (ovf) begin
			result.packed_value   = {item.sign_bit, ovf_mag};
			result.flag_inexact   = 1'b1;
			result.flag_underflow = 1'b0;
			result.flag_overflow  = ovf_flag;
		end else begin
			result.packed_value   = normal_val;
			result.flag_inexact   = rb != 3'b000;
			result.flag_underflow = tiny && rb != 3'b000;
			result.flag_overflow  = 1'b0;
		end
	end

endmodule

[hdl/fp8_e4m3_round_pack_top.sv]
// Top level: APB configuration, input register, rounding logic and result register.
`timescale 1ns / 1ps
// Rounds an unpacked sign/exponent/significand item to an 8-bit E4M3 float with
// inexact, underflow and overflow flags. Throughput is one item per cycle while
// results are taken; an item passes the input register, then the combinational
// rounding logic into the result register. The input side stalls
// only while both registers are full and the result is not taken. Configuration
// registers sit at byte addresses 0x00..0x14 (4 bytes apart) and must be written
// while the block is idle; pready is always high.
module fp8_e4m3_round_pack_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [fp8r_pkg::ADDR_W-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	fp8r_in_if.sink                       operand,
	fp8r_out_if.source                    result
);

	fp8r_pkg::fp8r_cfg_t    cfg_q;
	logic [2:0]             reg_idx;
	logic                   cfg_wr;
	logic                   valid_s1;
	fp8r_pkg::fp8r_item_t   item_s1;
	fp8r_pkg::fp8r_result_t res_comb;
	logic                   valid_s2;
	fp8r_pkg::fp8r_result_t res_s2;
	logic                   adv_s2;

	// APB register file
	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rounding_mode            <= fp8r_pkg::RM_NEAR_EVEN;
			cfg_q.tininess_before_rounding <= 1'b0;
			cfg_q.ofp8_format              <= 1'b1;
			cfg_q.saturate_enable          <= 1'b0;
			cfg_q.saturate_operations      <= 1'b0;
			cfg_q.overflow_flag_enable     <= 1'b1;
		end else if (cfg_wr) begin
			case (reg_idx)
				fp8r_pkg::REG_ROUND_MODE:  cfg_q.rounding_mode            <= pwdata[2:0];
				fp8r_pkg::REG_TINY_BEFORE: cfg_q.tininess_before_rounding <= pwdata[0];
				fp8r_pkg::REG_OFP8:        cfg_q.ofp8_format              <= pwdata[0];
				fp8r_pkg::REG_SAT_EN:      cfg_q.saturate_enable          <= pwdata[0];
				fp8r_pkg::REG_SAT_OPS:     cfg_q.saturate_operations      <= pwdata[0];
				fp8r_pkg::REG_OVF_FLAG_EN: cfg_q.overflow_flag_enable     <= pwdata[0];
				default: ;
			endcase
		end
	end

	// Register read mux
	always_comb begin
		case (reg_idx)
			fp8r_pkg::REG_ROUND_MODE:  prdata = {29'b0, cfg_q.rounding_mode};
			fp8r_pkg::REG_TINY_BEFORE: prdata = {31'b0, cfg_q.tininess_before_rounding};
			fp8r_pkg::REG_OFP8:        prdata = {31'b0, cfg_q.ofp8_format};
			fp8r_pkg::REG_SAT_EN:      prdata = {31'b0, cfg_q.saturate_enable};
			fp8r_pkg::REG_SAT_OPS:     prdata = {31'b0, cfg_q.saturate_operations};
			fp8r_pkg::REG_OVF_FLAG_EN: prdata = {31'b0, cfg_q.overflow_flag_enable};
			default:                   prdata = 32'b0;
		endcase
	end

	// Pipeline flow control
	assign adv_s2        = !valid_s2 || result.ready;
	assign operand.ready = !valid_s1 || adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (operand.ready) begin
				valid_s1 <= operand.valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// Input register: capture on transfer
	always_ff @(posedge clk) begin
		if (operand.valid && operand.ready) begin
			item_s1.sign_bit      <= operand.sign_bit;
			item_s1.exponent      <= operand.exponent;
			item_s1.significand   <= operand.significand;
			item_s1.is_conversion <= operand.is_conversion;
		end
	end

	fp8r_round u_round (
		.cfg    (cfg_q),
		.item   (item_s1),
		.result (res_comb)
	);

	// Result register
	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			res_s2 <= res_comb;
		end
	end

	assign result.valid          = valid_s2;
	assign result.packed_value   = res_s2.packed_value;
	assign result.flag_inexact   = res_s2.flag_inexact;
	assign result.flag_underflow = res_s2.flag_underflow;
	assign result.flag_overflow  = res_s2.flag_overflow;

	// Overflow never reports underflow and always reports inexact
	a_ovf_flags: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.flag_overflow |-> res_s2.flag_inexact && !res_s2.flag_underflow)
		else $error("overflow result with inconsistent flags");

	// Underflow implies inexact
	a_uf_inexact: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.flag_underflow |-> res_s2.flag_inexact)
		else $error("underflow without inexact");

	// Input side stalls only behind a full, stalled pipeline
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!operand.ready |-> valid_s1 && valid_s2 && !result.ready)
		else $error("input stalled with room in the pipeline");

	// An input transfer always lands in the input register
	a_fill_s1: assert property (@(posedge clk) disable iff (!arst_n)
		operand.valid && operand.ready |=> valid_s1)
		else $error("accepted item lost");

	// IEEE-like format never exceeds infinity in magnitude
	a_ieee_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !cfg_q.ofp8_format |-> res_s2.packed_value[6:0] <= fp8r_pkg::IEEE_INF)
		else $error("IEEE-like result beyond infinity");

endmodule
